// ===== sv/xrb_pkg.sv =====
// package for the xoshiro256** bounded random block
`timescale 1ns / 1ps
package xrb_pkg;
  localparam int WordW = 64;
  localparam int CmdW = 3;
  localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

  typedef enum logic [2:0] {
    CMD_RAW64 = 3'd0,
    CMD_UPPER32 = 3'd1,
    CMD_BOOL = 3'd2,
    CMD_BELOW = 3'd3,
    CMD_URANGE = 3'd4,
    CMD_SRANGE = 3'd5
  } cmd_t;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [WordW-1:0] bound;
    logic [WordW-1:0] low_value;
    logic [WordW-1:0] high_value;
  } req_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_LOAD,   // acc <= seed, idx <= 0
    OP_MIX0,        // z = acc + gamma; t = z ^ z>>30; clear product
    OP_MIX1,        // one 32x32 step of p = t * A
    OP_MIX2,        // t = p ^ p>>27; clear product
    OP_MIX3,        // one 32x32 step of p = t * B
    OP_MIX4,        // write word, idx++
    OP_FIXUP,       // zero check
    OP_LOAD_REQ,    // latch request, set limit
    OP_DRAW,        // one xoshiro step, latch raw
    OP_DIV_START,   // start modulo of thr
    OP_DIV_STEP,
    OP_THR_SAVE,
    OP_DIV2_START,  // start raw % limit
    OP_OUT          // form the result
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_bus_t;

  typedef struct packed {
    logic last_word;
    logic div_done;
    logic need_draw;
    logic bounded;
    logic trivial_zero;
    logic accept_draw;
    logic mul_done;
  } stat_bus_t;
endpackage

// ===== sv/xrb_if.sv =====
// valid/ready channel interface
`timescale 1ns / 1ps
interface xrb_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/xrb_datapath.sv =====
// datapath: state words, seed expansion, rejection and modulo unit
`timescale 1ns / 1ps
module xrb_datapath import xrb_pkg::*; (
  input  logic clk,
  input  logic [WordW-1:0] seed,
  input  logic [CmdW-1:0] req_cmd,
  input  logic [WordW-1:0] req_bound,
  input  logic [WordW-1:0] req_low,
  input  logic [WordW-1:0] req_high,
  input  cmd_bus_t ctl,
  output stat_bus_t st,
  output logic [WordW-1:0] result
);
  localparam int CntW = $clog2(WordW + 1);
  localparam int HalfW = WordW / 2;

  logic [WordW-1:0] w_r [4];
  logic [WordW-1:0] acc_r, t_r, p_r;
  logic [1:0] idx_r;
  logic [1:0] mcnt_r;
  logic any_r;
  logic [CmdW-1:0] cmd_r;
  logic [WordW-1:0] low_r, limit_r, thr_r, raw_r;
  logic bounded_r, zero_r;
  logic [WordW-1:0] rem_r, dend_r;
  logic [CntW-1:0] cnt_r;
  logic [WordW-1:0] res_r;
  logic [WordW:0] trial;
  logic [WordW-1:0] rot, mul5, span, mix_k, part;
  logic [HalfW-1:0] mul_a, mul_b;
  logic ugt, sgt;

  assign trial = {rem_r, dend_r[WordW-1]} - {1'b0, limit_r};
  assign mul5 = w_r[1] * 64'd5;
  assign rot = {mul5[WordW-8:0], mul5[WordW-1:WordW-7]};
  assign span = req_high - req_low + 64'd1;
  assign ugt = req_high > req_low;
  assign sgt = $signed(req_high) > $signed(req_low);

  // low 64 bits of t * k from three 32x32 partial products
  assign mix_k = (ctl.op == OP_MIX3) ? MixMulB : MixMulA;
  assign mul_a = (mcnt_r == 2'd2) ? t_r[WordW-1:HalfW] : t_r[HalfW-1:0];
  assign mul_b = (mcnt_r == 2'd1) ? mix_k[WordW-1:HalfW] : mix_k[HalfW-1:0];
  assign part = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};

  always_ff @(posedge clk) begin
    case (ctl.op) inside
      OP_SEED_LOAD: begin
        acc_r <= seed; idx_r <= '0; any_r <= 1'b0;
      end
      OP_MIX0: begin
        acc_r <= acc_r + GoldenGamma;
        t_r <= (acc_r + GoldenGamma) ^ ((acc_r + GoldenGamma) >> 30);
        p_r <= '0; mcnt_r <= '0;
      end
      OP_MIX1, OP_MIX3: begin
        if (mcnt_r == 2'd0) p_r <= p_r + part;
        else p_r <= p_r + {part[HalfW-1:0], {HalfW{1'b0}}};
        mcnt_r <= mcnt_r + 2'd1;
      end
      OP_MIX2: begin
        t_r <= p_r ^ (p_r >> 27);
        p_r <= '0; mcnt_r <= '0;
      end
      OP_MIX4: begin
        w_r[idx_r] <= p_r ^ (p_r >> 31);
        if ((p_r ^ (p_r >> 31)) != '0) any_r <= 1'b1;
        idx_r <= idx_r + 2'd1;
      end
      OP_FIXUP: if (!any_r) w_r[0] <= GoldenGamma;
      OP_LOAD_REQ: begin
        cmd_r <= req_cmd;
        case (req_cmd)
          CMD_BELOW: begin
            limit_r <= req_bound; low_r <= '0; bounded_r <= 1'b1;
            zero_r <= req_bound == '0;
          end
          CMD_URANGE: begin
            limit_r <= span; low_r <= req_low; bounded_r <= 1'b1;
            zero_r <= !ugt || span == '0;
          end
          CMD_SRANGE: begin
            limit_r <= span; low_r <= req_low; bounded_r <= 1'b1;
            zero_r <= !sgt || span == '0;
          end
          default: begin
            limit_r <= '0; low_r <= req_low; bounded_r <= 1'b0; zero_r <= 1'b0;
          end
        endcase
      end
      OP_DRAW: begin
        raw_r <= rot * 64'd9;
        w_r[2] <= w_r[2] ^ w_r[0] ^ (w_r[1] << 17);
        w_r[3] <= {(w_r[3] ^ w_r[1]) << 45} | ((w_r[3] ^ w_r[1]) >> 19);
        w_r[1] <= w_r[1] ^ w_r[2] ^ w_r[0];
        w_r[0] <= w_r[0] ^ w_r[3] ^ w_r[1];
      end
      OP_DIV_START: begin
        dend_r <= '0 - limit_r; rem_r <= '0; cnt_r <= '0;
      end
      OP_DIV2_START: begin
        dend_r <= raw_r; rem_r <= '0; cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        if (!trial[WordW]) rem_r <= trial[WordW-1:0];
        else rem_r <= {rem_r[WordW-2:0], dend_r[WordW-1]};
        dend_r <= {dend_r[WordW-2:0], 1'b0};
        cnt_r <= cnt_r + CntW'(1);
      end
      OP_THR_SAVE: thr_r <= rem_r;
      OP_OUT: begin
        case (cmd_r) inside
          CMD_RAW64: res_r <= raw_r;
          CMD_UPPER32: res_r <= {{HalfW{1'b0}}, raw_r[WordW-1:HalfW]};
          CMD_BOOL: res_r <= {{(WordW-1){1'b0}}, raw_r[0]};
          CMD_BELOW, CMD_URANGE, CMD_SRANGE:
            res_r <= zero_r ? low_r : low_r + rem_r;
          default: res_r <= '0;
        endcase
      end
      default: ;
    endcase
  end

  assign st.last_word = idx_r == 2'd3;
  assign st.div_done = cnt_r == CntW'(WordW - 1);
  assign st.need_draw = cmd_r <= CMD_BOOL;
  assign st.bounded = bounded_r;
  assign st.trivial_zero = zero_r;
  assign st.accept_draw = raw_r >= thr_r;
  assign st.mul_done = mcnt_r == 2'd2;
  assign result = res_r;
endmodule

// ===== sv/xrb_ctrl.sv =====
// controller state machine
`timescale 1ns / 1ps
module xrb_ctrl import xrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  xrb_if.sink req,
  xrb_if.sink cfg,
  xrb_if.source rsp,
  input  stat_bus_t st,
  output cmd_bus_t ctl
);
  typedef enum logic [3:0] {
    S_SEED, S_M0, S_M1, S_M2, S_M3, S_M4, S_FIX, S_IDLE, S_REQ, S_THR,
    S_THRDIV, S_DRAW, S_CHK, S_MOD, S_OUT, S_HOLD
  } state_t;
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign req.ready = state_r == S_IDLE && !cfg.valid;
  assign cfg.ready = state_r == S_IDLE;
  assign rsp.valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    ctl.op = OP_NONE;
    if (out_valid_r && rsp.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_SEED: begin ctl.op = OP_SEED_LOAD; state_nxt = S_M0; end
      S_M0: begin ctl.op = OP_MIX0; state_nxt = S_M1; end
      S_M1: begin
        ctl.op = OP_MIX1;
        if (st.mul_done) state_nxt = S_M2;
      end
      S_M2: begin ctl.op = OP_MIX2; state_nxt = S_M3; end
      S_M3: begin
        ctl.op = OP_MIX3;
        if (st.mul_done) state_nxt = S_M4;
      end
      S_M4: begin
        ctl.op = OP_MIX4;
        state_nxt = st.last_word ? S_FIX : S_M0;
      end
      S_FIX: begin ctl.op = OP_FIXUP; state_nxt = S_IDLE; end
      S_IDLE: begin
        if (cfg.valid) state_nxt = S_SEED;
        else if (req.valid) begin ctl.op = OP_LOAD_REQ; state_nxt = S_REQ; end
      end
      S_REQ: begin
        if (!st.bounded) state_nxt = st.need_draw ? S_DRAW : S_OUT;
        else if (st.trivial_zero) state_nxt = S_OUT;
        else begin ctl.op = OP_DIV_START; state_nxt = S_THR; end
      end
      S_THR: begin
        ctl.op = OP_DIV_STEP;
        if (st.div_done) state_nxt = S_THRDIV;
      end
      S_THRDIV: begin ctl.op = OP_THR_SAVE; state_nxt = S_DRAW; end
      S_DRAW: begin ctl.op = OP_DRAW; state_nxt = S_CHK; end
      S_CHK: begin
        if (!st.bounded) state_nxt = S_OUT;
        else if (st.accept_draw) begin ctl.op = OP_DIV2_START; state_nxt = S_MOD; end
        else state_nxt = S_DRAW;
      end
      S_MOD: begin
        ctl.op = OP_DIV_STEP;
        if (st.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || rsp.ready) begin
          ctl.op = OP_OUT; state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin out_valid_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== sv/xoshiro256ss_bounded_random.sv =====
// top level of the xoshiro256** bounded random block
`timescale 1ns / 1ps
// One result per request, one request in flight at a time. Raw, upper32 and
// bool requests make one draw and then raise out_valid; unused command codes, a
// zero bound and an empty, single-value or full-width range make no draw.
// Other bounded requests run a 64-step shift-subtract modulo unit twice
// (threshold, then reduction) and draw again after each rejected draw.
// The next request is accepted in the cycle out_valid rises if no seed write
// is pending; a result still waiting on out_ready holds the block before its
// successor is written. A seed write, and reset, re-expand the four state
// words, the 64-bit mixing multiplies being done as three 32x32 steps each.
module xoshiro256ss_bounded_random import xrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [CmdW-1:0] in_cmd,
  input  logic [WordW-1:0] in_bound,
  input  logic [WordW-1:0] in_low_value,
  input  logic [WordW-1:0] in_high_value,
  output logic out_valid,
  input  logic out_ready,
  output logic [WordW-1:0] out_value,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [WordW-1:0] cfg_seed
);
  cmd_bus_t ctl;
  stat_bus_t st;
  logic [WordW-1:0] seed_r;

  xrb_if #(.payload_t(req_t)) in_ch ();
  xrb_if #(.payload_t(word_t)) out_ch ();
  xrb_if #(.payload_t(word_t)) cfg_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.payload = {in_cmd, in_bound, in_low_value, in_high_value};
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_value = out_ch.payload;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.payload = cfg_seed;
  assign cfg_ready = cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= '0;
    else if (cfg_ch.valid && cfg_ch.ready) seed_r <= cfg_ch.payload;
  end

  xrb_ctrl u_ctrl (
    .clk, .rst_n, .req(in_ch), .cfg(cfg_ch), .rsp(out_ch), .st, .ctl
  );

  xrb_datapath u_dp (
    .clk, .seed(seed_r), .req_cmd(in_ch.payload.cmd),
    .req_bound(in_ch.payload.bound), .req_low(in_ch.payload.low_value),
    .req_high(in_ch.payload.high_value), .ctl, .st,
    .result(out_ch.payload)
  );
endmodule
